// ===== rtl/core/ndat_pkg.sv =====
// ----------------------------------------------------------------------------
// ndat_pkg
// Shared types and constants for the node discovery aging table.
// ----------------------------------------------------------------------------
`default_nettype none

package ndat_pkg;

  localparam int MAX_NODES_DEF = 16;

  // announcement header and layout
  localparam logic [7:0] TOKEN_NODE_INFO = 8'd255;
  localparam logic [7:0] ID_NODE_INFO    = 8'd1;
  localparam logic [5:0] POS_TOKEN       = 6'd0;
  localparam logic [5:0] POS_ID          = 6'd1;
  localparam logic [5:0] POS_IP_FIRST    = 6'd2;
  localparam logic [5:0] POS_IP_LAST     = 6'd5;
  localparam logic [5:0] POS_TYPE        = 6'd38;
  localparam logic [5:0] POS_UNIT        = 6'd39;
  localparam logic [5:0] POS_BUILD_FIRST = 6'd40;
  localparam logic [5:0] POS_BUILD_LAST  = 6'd43;
  localparam logic [5:0] MIN_LEN_RECOG   = 6'd40;
  localparam logic [5:0] MIN_LEN_BUILD   = 6'd44;
  localparam logic [5:0] BYTE_COUNT_MAX  = 6'd63;
  localparam logic [3:0] AGE_LIMIT       = 4'd10;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       supplementary_port;
    logic       sender_is_self;
    logic [7:0] query_unit;
  } cmd_t;

  typedef struct packed {
    logic        packet_recognized;
    logic        entry_written;
    logic        dropped_table_full;
    logic [4:0]  removed_count;
    logic [4:0]  entries_in_use;
    logic        found;
    logic [31:0] found_ip;
    logic [7:0]  found_type;
    logic [31:0] found_build;
    logic [3:0]  found_age;
  } result_t;

  // what the capture stage hands over at the final byte
  typedef struct packed {
    logic        recognized;
    logic [7:0]  unit;
    logic [31:0] ip;
    logic [7:0]  ntype;
    logic [31:0] build;
  } pkt_info_t;

  typedef struct packed {
    logic [7:0]  unit;
    logic [31:0] ip;
    logic [7:0]  ntype;
    logic [31:0] build;
    logic [3:0]  age;
  } slot_t;

endpackage

`default_nettype wire

// ===== rtl/core/node_discovery_aging_table_core.sv =====
// ----------------------------------------------------------------------------
// node_discovery_aging_table_core
// Neighbour table fed by announcement bytes, with aging ticks and lookups.
//
//   channel   signals                        handshake
//   command   start, cmd, busy               taken when start & !busy
//   result    done, result                   one cycle strobe, no back-pressure
//   config    cfg_valid, cfg_data, cfg_ready write when cfg_valid & cfg_ready
//
// A non-final byte is taken while idle and busy stays low. A final byte
// that updates nothing finishes at once; its result word follows in the cycle
// after acceptance. Kind 3 is taken and dropped with no result. Table work
// walks the slots through the entry RAM, a read step and a check step per
// slot; a table update that writes a slot ends with a write step.
// Reset empties the table by clearing its valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module node_discovery_aging_table_core import ndat_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire cmd_t cmd,
  output logic      busy,
  output logic      done,
  output result_t   result,
  input  wire logic cfg_valid,
  input  wire logic cfg_data,
  output logic      cfg_ready
);

  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NODES - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_CK   = 4'b0100,
    ST_WR   = 4'b1000
  } state_t;

  state_t               state, state_next;
  logic [1:0]           op;
  logic [IDX_W-1:0]     idx, idx_next;
  logic [IDX_W-1:0]     target, target_next;
  logic [IDX_W-1:0]     free_idx, free_idx_next;
  logic                 free_found, free_found_next;
  logic                 is_new, is_new_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [CNT_W-1:0]     removed, removed_next;
  logic [MAX_NODES-1:0] valid, valid_next;
  logic                 list_enable;
  pkt_info_t            pkt;
  logic [7:0]           qunit;

  logic                 accept;
  logic                 fin;
  result_t              res_next;
  pkt_info_t            cap_info;
  slot_t                rd;
  slot_t                wr;
  logic [$bits(slot_t)-1:0] rdata;
  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic                 v;
  logic                 at_last;
  logic                 unit_hit;
  logic                 keep;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  ndat_capture u_capture (
    .clk                (clk),
    .rst                (rst),
    .byte_en            (accept && (cmd.kind == KIND_BYTE)),
    .data_byte          (cmd.data_byte),
    .last_byte          (cmd.last_byte),
    .supplementary_port (cmd.supplementary_port),
    .info               (cap_info)
  );

  ndat_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (MAX_NODES)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr),
    .raddr (idx),
    .rdata (rdata)
  );

  assign rd       = slot_t'(rdata);
  assign v        = valid[idx];
  assign at_last  = (idx == LAST_IDX);
  assign unit_hit = v && (rd.unit == ((op == KIND_BYTE) ? pkt.unit : qunit));
  assign keep     = (rd.ip[7:0] != 8'd0) && (rd.age < AGE_LIMIT);

  // entry write: fresh announcement, or an aged entry written back
  always_comb begin
    if (state == ST_WR) begin
      we       = 1'b1;
      waddr    = target;
      wr.unit  = pkt.unit;
      wr.ip    = pkt.ip;
      wr.ntype = pkt.ntype;
      wr.build = pkt.build;
      wr.age   = '0;
    end else begin
      we       = (state == ST_CK) && (op == KIND_TICK) && v && keep;
      waddr    = idx;
      wr       = rd;
      wr.age   = rd.age + 4'd1;
    end
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    target_next     = target;
    free_idx_next   = free_idx;
    free_found_next = free_found;
    is_new_next     = is_new;
    count_next      = count;
    removed_next    = removed;
    valid_next      = valid;
    fin             = 1'b0;
    res_next        = '0;
    res_next.entries_in_use = 5'(count);

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd.kind)
            KIND_BYTE: begin
              if (cmd.last_byte) begin
                if (cap_info.recognized && list_enable && !cmd.sender_is_self) begin
                  state_next      = ST_RD;
                  idx_next        = '0;
                  free_found_next = 1'b0;
                end else begin
                  fin = 1'b1;
                  res_next.packet_recognized = cap_info.recognized;
                end
              end
            end
            KIND_TICK: begin
              state_next   = ST_RD;
              idx_next     = '0;
              removed_next = '0;
            end
            KIND_QUERY: begin
              state_next = ST_RD;
              idx_next   = '0;
            end
            default: ;
          endcase
        end
      end

      ST_RD: state_next = ST_CK;

      ST_CK: begin
        case (op)
          KIND_BYTE: begin
            if (unit_hit) begin
              target_next = idx;
              is_new_next = 1'b0;
              state_next  = ST_WR;
            end else begin
              if (!v && !free_found) begin
                free_found_next = 1'b1;
                free_idx_next   = idx;
              end
              if (at_last) begin
                if (free_found || !v) begin
                  target_next = free_found ? free_idx : idx;
                  is_new_next = 1'b1;
                  state_next  = ST_WR;
                end else begin
                  fin        = 1'b1;
                  state_next = ST_IDLE;
                  res_next.packet_recognized  = 1'b1;
                  res_next.dropped_table_full = 1'b1;
                end
              end else begin
                idx_next   = idx + 1'b1;
                state_next = ST_RD;
              end
            end
          end
          KIND_TICK: begin
            if (v && !keep) begin
              valid_next[idx] = 1'b0;
              removed_next    = removed + 1'b1;
              count_next      = count - 1'b1;
            end
            if (at_last) begin
              fin        = 1'b1;
              state_next = ST_IDLE;
              res_next.removed_count  = 5'(removed_next);
              res_next.entries_in_use = 5'(count_next);
            end else begin
              idx_next   = idx + 1'b1;
              state_next = ST_RD;
            end
          end
          KIND_QUERY: begin
            if (unit_hit) begin
              fin        = 1'b1;
              state_next = ST_IDLE;
              res_next.found       = 1'b1;
              res_next.found_ip    = rd.ip;
              res_next.found_type  = rd.ntype;
              res_next.found_build = rd.build;
              res_next.found_age   = rd.age;
            end else if (at_last) begin
              fin        = 1'b1;
              state_next = ST_IDLE;
            end else begin
              idx_next   = idx + 1'b1;
              state_next = ST_RD;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end

      ST_WR: begin
        valid_next[target] = 1'b1;
        if (is_new) begin
          count_next = count + 1'b1;
        end
        fin        = 1'b1;
        state_next = ST_IDLE;
        res_next.packet_recognized = 1'b1;
        res_next.entry_written     = 1'b1;
        res_next.entries_in_use    = 5'(count_next);
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      valid       <= '0;
      count       <= '0;
      done        <= 1'b0;
      list_enable <= 1'b1;
    end else begin
      state <= state_next;
      valid <= valid_next;
      count <= count_next;
      done  <= fin;
      if (cfg_valid && cfg_ready) begin
        list_enable <= cfg_data;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    target     <= target_next;
    free_idx   <= free_idx_next;
    free_found <= free_found_next;
    is_new     <= is_new_next;
    removed    <= removed_next;
    if (accept) begin
      op    <= cmd.kind;
      qunit <= cmd.query_unit;
      pkt   <= cap_info;
    end
    if (fin) begin
      result <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ndat_ram.sv =====
// ----------------------------------------------------------------------------
// ndat_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ndat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/ndat_capture.sv =====
// ----------------------------------------------------------------------------
// ndat_capture
// Byte-wise header capture of a node announcement; cleared after each final
// byte. Presents the decoded packet for the byte now being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ndat_capture import ndat_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_en,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  input  wire logic       supplementary_port,
  output pkt_info_t       info
);

  logic [5:0]  byte_count, byte_count_next;
  logic [7:0]  token, token_next;
  logic [7:0]  id, id_next;
  logic [31:0] ip, ip_next;
  logic [7:0]  ntype, ntype_next;
  logic [7:0]  unit, unit_next;
  logic [31:0] build, build_next;
  logic [1:0]  ip_lane;

  always_comb begin
    token_next = token;
    id_next    = id;
    ip_next    = ip;
    ntype_next = ntype;
    unit_next  = unit;
    build_next = build;
    // positions 2..5 map onto lanes 0..3 by their low two bits less two
    ip_lane    = byte_count[1:0] - 2'd2;
    if (byte_count == POS_TOKEN) begin
      token_next = data_byte;
    end else if (byte_count == POS_ID) begin
      id_next = data_byte;
    end else if (byte_count inside {[POS_IP_FIRST:POS_IP_LAST]}) begin
      ip_next[{ip_lane, 3'b000} +: 8] = data_byte;
    end else if (byte_count == POS_TYPE) begin
      ntype_next = data_byte;
    end else if (byte_count == POS_UNIT) begin
      unit_next = data_byte;
    end else if (byte_count inside {[POS_BUILD_FIRST:POS_BUILD_LAST]}) begin
      build_next[{byte_count[1:0], 3'b000} +: 8] = data_byte;
    end
    byte_count_next = (byte_count == BYTE_COUNT_MAX) ? byte_count : byte_count + 6'd1;

    info.recognized = supplementary_port && (token_next == TOKEN_NODE_INFO) &&
                      (id_next == ID_NODE_INFO) && (byte_count_next >= MIN_LEN_RECOG);
    info.unit       = unit_next;
    info.ip         = ip_next;
    info.ntype      = ntype_next;
    info.build      = (byte_count_next >= MIN_LEN_BUILD) ? build_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || (byte_en && last_byte)) begin
      byte_count <= '0;
      token      <= '0;
      id         <= '0;
      ip         <= '0;
      ntype      <= '0;
      unit       <= '0;
      build      <= '0;
    end else if (byte_en) begin
      byte_count <= byte_count_next;
      token      <= token_next;
      id         <= id_next;
      ip         <= ip_next;
      ntype      <= ntype_next;
      unit       <= unit_next;
      build      <= build_next;
    end
  end

endmodule

`default_nettype wire
